/* hdl/ecr_pkg.sv */
// shared types and constants of the epsilon closure unit
`default_nettype none

package ecr_pkg;

  localparam int MaxStatesDef = 16;
  localparam int StateW       = 4;
  localparam int StateCountW  = 5;
  localparam int MaskW        = 16;
  localparam int CmpW         = 7;

  localparam logic [StateCountW-1:0] StateCountRst = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic add_start;
    logic add_write;
    logic clear_all;
    logic query_start;
    logic scan_step;
    logic load_out;
  } ecr_cmd_t;

  typedef struct packed {
    logic from_ok;
    logic to_ok;
    logic scan_done;
  } ecr_sts_t;

endpackage

`default_nettype wire

/* hdl/ecr_ctrl.sv */
// control state machine of the epsilon closure unit
`default_nettype none

module ecr_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              operation_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  input  wire ecr_pkg::ecr_sts_t       sts_i,
  output ecr_pkg::ecr_cmd_t            cmd_o
);
  import ecr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ADD    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_ADD: begin
              if (sts_i.from_ok && sts_i.to_ok) begin
                cmd_o.add_start = 1'b1;
                state_d         = ST_ADD;
              end
            end
            OP_CLEAR: begin
              cmd_o.clear_all = 1'b1;
            end
            OP_QUERY: begin
              cmd_o.query_start = 1'b1;
              state_d           = sts_i.from_ok ? ST_SCAN : ST_FINISH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.add_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/ecr_dp.sv */
// datapath of the epsilon closure unit: edge memory, search masks, result register
`default_nettype none

module ecr_dp #(
  parameter int MAX_STATES = ecr_pkg::MaxStatesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ecr_pkg::StateCountW-1:0] cfg_wdata_i,
  input  wire logic [ecr_pkg::StateW-1:0]      from_state_i,
  input  wire logic [ecr_pkg::StateW-1:0]      to_state_i,
  input  wire ecr_pkg::ecr_cmd_t               cmd_i,
  output ecr_pkg::ecr_sts_t                    sts_o,
  output logic [ecr_pkg::MaskW-1:0]            closure_mask_o,
  output logic                                 start_in_range_o
);
  import ecr_pkg::*;

  localparam int AddrW = $clog2(MAX_STATES);

  typedef logic [MAX_STATES-1:0] row_t;

  function automatic logic [AddrW-1:0] enc_onehot(input row_t v);
    logic [AddrW-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (v[i]) begin
        idx = idx | AddrW'(i);
      end
    end
    return idx;
  endfunction

  logic [StateCountW-1:0] state_count_q;
  logic [CmpW-1:0]        cnt_ext;
  row_t                   range_mask;
  logic [AddrW-1:0]       from_addr;
  logic [AddrW-1:0]       to_addr;
  logic [AddrW-1:0]       wr_addr_q;
  logic [AddrW-1:0]       to_q;
  logic [AddrW-1:0]       pick_addr;
  logic [AddrW-1:0]       rd_addr;
  logic                   rd_en;

  row_t                   mem_q [MAX_STATES];
  row_t                   row_valid_q;
  row_t                   rdata_q;
  logic                   rvalid_q;
  row_t                   row_in;

  row_t                   reached_q, reached_d;
  row_t                   frontier_q, frontier_d;
  logic                   pend_q, pend_d;
  logic                   start_ok_q, start_ok_d;
  row_t                   lowest;
  row_t                   fresh;
  row_t                   from_hot;
  logic                   issue;

  logic [MaskW-1:0]       closure_q;
  logic                   sir_q;

  assign cnt_ext   = CmpW'(state_count_q);
  assign from_addr = AddrW'(from_state_i);
  assign to_addr   = AddrW'(to_state_i);

  always_comb begin
    for (int i = 0; i < MAX_STATES; i++) begin
      range_mask[i] = (CmpW'(i) < cnt_ext);
    end
  end

  assign sts_o.from_ok = (CmpW'(from_state_i) < cnt_ext) &&
                         (CmpW'(from_state_i) < CmpW'(MAX_STATES));
  assign sts_o.to_ok   = (CmpW'(to_state_i) < cnt_ext) &&
                         (CmpW'(to_state_i) < CmpW'(MAX_STATES));
  assign sts_o.scan_done = (frontier_q == '0) && !pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= StateCountRst;
    end else if (cfg_we_i) begin
      state_count_q <= cfg_wdata_i;
    end
  end

  // edge memory, rows not yet written since the last clear read as empty
  assign row_in    = rvalid_q ? rdata_q : '0;
  assign lowest    = frontier_q & (~frontier_q + row_t'(1));
  assign pick_addr = enc_onehot(lowest);
  assign issue     = cmd_i.scan_step && (frontier_q != '0);
  assign rd_en     = cmd_i.add_start || issue;
  assign rd_addr   = cmd_i.add_start ? from_addr : pick_addr;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= mem_q[rd_addr];
      rvalid_q <= row_valid_q[rd_addr];
    end
    if (cmd_i.add_write) begin
      mem_q[wr_addr_q] <= row_in | (row_t'(1) << to_q);
    end
    if (cmd_i.add_start) begin
      wr_addr_q <= from_addr;
      to_q      <= to_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      row_valid_q <= '0;
    end else if (cmd_i.add_write) begin
      row_valid_q[wr_addr_q] <= 1'b1;
    end
  end

  // breadth search, one row read issued per cycle while the frontier holds states, results merge behind it
  assign from_hot = row_t'(1) << from_addr;
  assign fresh    = pend_q ? (row_in & range_mask & ~reached_q) : '0;

  always_comb begin
    reached_d  = reached_q;
    frontier_d = frontier_q;
    pend_d     = pend_q;
    start_ok_d = start_ok_q;
    if (cmd_i.query_start) begin
      reached_d  = sts_o.from_ok ? from_hot : '0;
      frontier_d = reached_d;
      pend_d     = 1'b0;
      start_ok_d = sts_o.from_ok;
    end else if (cmd_i.scan_step) begin
      reached_d  = reached_q | fresh;
      frontier_d = (frontier_q & ~(issue ? lowest : '0)) | fresh;
      pend_d     = issue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frontier_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      frontier_q <= frontier_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reached_q  <= reached_d;
    start_ok_q <= start_ok_d;
    if (cmd_i.load_out) begin
      closure_q <= MaskW'(reached_q);
      sir_q     <= start_ok_q;
    end
  end

  assign closure_mask_o   = closure_q;
  assign start_in_range_o = sir_q;

endmodule

`default_nettype wire

/* hdl/epsilon_closure_reach_core.sv */
// top level of the epsilon closure unit
`default_nettype none

// Keeps an epsilon-transition graph as one adjacency row per state in a small
// memory and answers closure queries with a breadth search. The edge memory has
// one registered read port. An add reads the row, then writes it back. A clear
// or an unused operation code completes without leaving the idle state. The
// start row read of a query is followed by a wait for that row. States already
// waiting in the frontier are then read back to back, but a state found by the
// row just read must first be merged into the frontier. An out-of-range start
// skips the search and goes straight to the finish state. A finished result
// sits in an output register, so the next item is taken while it waits. A query
// that finishes while that register is still full holds until the register is
// taken. The user must write state_count only while the unit is idle; the block
// itself does not enforce it.
module epsilon_closure_reach_core #(
  parameter int MAX_STATES = ecr_pkg::MaxStatesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ecr_pkg::StateCountW-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [ecr_pkg::StateW-1:0]      from_state_i,
  input  wire logic [ecr_pkg::StateW-1:0]      to_state_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [ecr_pkg::MaskW-1:0]            closure_mask_o,
  output logic                                 start_in_range_o
);
  import ecr_pkg::*;

  ecr_cmd_t cmd;
  ecr_sts_t sts;

  ecr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ecr_dp #(
    .MAX_STATES(MAX_STATES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .from_state_i     (from_state_i),
    .to_state_i       (to_state_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .closure_mask_o   (closure_mask_o),
    .start_in_range_o (start_in_range_o)
  );

endmodule

`default_nettype wire

/* hdl/ecr_checker.sv */
// port-level assertions of the epsilon closure unit and their binding
`default_nettype none

module ecr_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_i,
  input wire logic [1:0]                 operation_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_stall_i,
  input wire logic [ecr_pkg::MaskW-1:0]  closure_mask_i,
  input wire logic                       start_in_range_i
);
  import ecr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(closure_mask_i) &&
                                   $stable(start_in_range_i))
    else $error("stalled result item changed");

  a_bad_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !start_in_range_i |-> closure_mask_i == '0)
    else $error("out-of-range query returned a nonzero mask");

  a_start_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_in_range_i |-> closure_mask_i != '0)
    else $error("closure misses its start state");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && (operation_i == OP_QUERY) |=> in_stall_i)
    else $error("query item did not occupy the unit");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result item appeared without a query in progress");

endmodule

bind epsilon_closure_reach_core ecr_checker u_ecr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .operation_i      (operation_i),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .closure_mask_i   (closure_mask_o),
  .start_in_range_i (start_in_range_o)
);

`default_nettype wire
